/* hdl/trpid_pkg.sv */
package trpid_pkg;

  // Shared datapath widths
  localparam int unsigned NUM_W   = 48;   // divider dividend / quotient
  localparam int unsigned DEN_W   = 32;   // divider divisor
  localparam int unsigned MUL_A_W = 33;   // signed multiplier operand
  localparam int unsigned MUL_B_W = 32;   // unsigned multiplier operand
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W + 1;
  localparam int unsigned ACC_W   = 98;   // control sum accumulator
  localparam int unsigned OHMS_W  = 24;
  localparam int unsigned ERR_W   = 32;   // Q8.24 error
  localparam int unsigned ERR_FRAC = 24;
  localparam int unsigned INT_W   = 64;
  localparam int unsigned SER_W   = 20;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  localparam logic [OHMS_W-1:0] OHMS_MAX = '1;
  localparam logic [ERR_W-1:0]  ERR_MAX  = 32'h7FFF_FFFF;
  localparam logic [ERR_W-1:0]  ERR_ONE  = 32'h0100_0000;
  // largest quotient that still gives an error inside Q8.24
  localparam logic [NUM_W-1:0]  ERR_LIM  = 48'h0000_80FF_FFFF;
  localparam logic [SER_W-1:0]  SERIES_RST = 20'd100000;
  localparam logic [MUL_A_W-1:0] MS_PER_S = 33'd1000;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_KP     = 3'd0,
    REG_KI     = 3'd1,
    REG_KD     = 3'd2,
    REG_TARGET = 3'd3,
    REG_SERIES = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_HIGH = 2'd1,
    CLAMP_LOW  = 2'd2
  } clamp_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RES_MUL,
    ST_RES_DIV,
    ST_RES_WAIT,
    ST_ERR_DIV,
    ST_ERR_WAIT,
    ST_INT_MUL,
    ST_INT_ADD,
    ST_DER_MUL,
    ST_DER_DIV,
    ST_DER_WAIT,
    ST_KP_MUL,
    ST_KI_LO,
    ST_KI_HI,
    ST_KD_LO,
    ST_KD_HI,
    ST_ACC_LAST,
    ST_DONE
  } state_e;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

/* hdl/trpid_in_if.sv */
interface trpid_in_if #(
  parameter int unsigned ADC_BITS  = 10,
  parameter int unsigned STEP_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [ADC_BITS-1:0]  adc_sample;
  logic [STEP_BITS-1:0] step_ms;

  modport source (output valid, adc_sample, step_ms, input ready);
  modport sink   (input valid, adc_sample, step_ms, output ready);
endinterface

/* hdl/trpid_out_if.sv */
interface trpid_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  heater_duty;
  logic [23:0] measured_ohms;
  logic        settled;
  logic [1:0]  clamp_state;

  modport source (output valid, heater_duty, measured_ohms, settled, clamp_state,
                  input ready);
  modport sink   (input valid, heater_duty, measured_ohms, settled, clamp_state,
                  output ready);
endinterface

/* hdl/trpid_div.sv */
module trpid_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trpid_pkg::div_req_t req_i,
  output trpid_pkg::div_rsp_t rsp_o
);
  import trpid_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q;   // dividend bits shift out, quotient bits shift in
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;
  logic             fits;

  // One restoring step per cycle
  always_comb begin
    shifted = {rem_q, num_q[NUM_W-1]};
    trial   = shifted - {1'b0, den_q};
    fits    = (shifted >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], fits};
      rem_q <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

endmodule

/* hdl/thermistor_resistance_pid_unit.sv */
// Channel  Dir  Payload                                            Transfer
// in_i     in   adc_sample, step_ms                                valid & ready
// out_o    out  heater_duty, measured_ohms, settled, clamp_state   valid & ready
// apb      in   kp, ki, kd, target_ohms, series_ohms at 4*index    psel & penable & pwrite
//
// Each item goes through three 48-step divisions on the shared restoring divider
// (resistance, error, derivative), plus multiplies and accumulation on the single
// 33x32 multiplier, then result load and a return to idle. A zero sample, a zero
// resistance or a zero step skips its division.
// in_i is ready only while the sequencer is idle; the result sits in an output
// register, so the next item is taken while it waits, and the sequencer holds in
// its last state only if a second result finds that register still full.
// Reset (rst_ni low) returns the registers to their reset values (series 100000) and
// clears the integral and the previous error.
module thermistor_resistance_pid_unit #(
  parameter int unsigned ADC_BITS       = 10,
  parameter int unsigned STEP_BITS      = 16,
  parameter int unsigned GAIN_FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  trpid_in_if.sink                           in_i,
  trpid_out_if.source                        out_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [trpid_pkg::PADDR_W-1:0]      paddr,
  input  logic [trpid_pkg::PDATA_W-1:0]      pwdata,
  output logic [trpid_pkg::PDATA_W-1:0]      prdata,
  output logic                               pready
);
  import trpid_pkg::*;

  localparam int unsigned FRAC = ERR_FRAC + GAIN_FRAC_BITS;
  localparam logic [ADC_BITS-1:0] ADC_FULL = '1;
  localparam logic [ACC_W-1:0]    DUTY_TOP = ACC_W'(255) << FRAC;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic signed [31:0]  kp_q, ki_q, kd_q;
  logic [OHMS_W-1:0]   target_q;
  logic [SER_W-1:0]    series_q;
  logic                cfg_wr;
  logic                wr_target;

  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite;
  assign wr_target = cfg_wr && (paddr[4:2] == REG_TARGET);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= '0;
      ki_q     <= '0;
      kd_q     <= '0;
      target_q <= '0;
      series_q <= SERIES_RST;
    end else if (cfg_wr) begin
      unique case (cfg_reg_e'(paddr[4:2]))
        REG_KP:     kp_q     <= pwdata;
        REG_KI:     ki_q     <= pwdata;
        REG_KD:     kd_q     <= pwdata;
        REG_TARGET: target_q <= pwdata[OHMS_W-1:0];
        REG_SERIES: series_q <= pwdata[SER_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (cfg_reg_e'(paddr[4:2]))
      REG_KP:     prdata = kp_q;
      REG_KI:     prdata = ki_q;
      REG_KD:     prdata = kd_q;
      REG_TARGET: prdata = PDATA_W'(target_q);
      REG_SERIES: prdata = PDATA_W'(series_q);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer and datapath registers
  state_e state_q, state_d;

  logic [ADC_BITS-1:0]       adc_q;
  logic [STEP_BITS-1:0]      dt_q;
  logic [OHMS_W-1:0]         ohms_q;
  logic [ERR_W-1:0]          err_q;
  logic [ERR_W-1:0]          prev_q;
  logic [INT_W-1:0]          integ_q;
  logic [NUM_W-1:0]          dmag_q;
  logic                      dneg_q;
  logic signed [MUL_P_W-1:0] mul_q;
  logic [ACC_W-1:0]          acc_q;
  logic                      acc_en_q, acc_sh_q, acc_add_q;

  logic                      oval_q;
  logic [7:0]                duty_q;
  logic [OHMS_W-1:0]         oohms_q;
  logic                      osettled_q;
  clamp_e                    oclamp_q;

  logic       in_xfer;
  logic       out_free;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  assign in_xfer  = in_i.valid & in_i.ready;
  assign out_free = !oval_q || out_o.ready;

  trpid_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_xfer) state_d = ST_RES_MUL;
      ST_RES_MUL:  state_d = ST_RES_DIV;
      ST_RES_DIV:  state_d = (adc_q == '0) ? ST_ERR_DIV : ST_RES_WAIT;
      ST_RES_WAIT: if (div_rsp.done) state_d = ST_ERR_DIV;
      ST_ERR_DIV:  state_d = (ohms_q == '0) ? ST_INT_MUL : ST_ERR_WAIT;
      ST_ERR_WAIT: if (div_rsp.done) state_d = ST_INT_MUL;
      ST_INT_MUL:  state_d = ST_INT_ADD;
      ST_INT_ADD:  state_d = ST_DER_MUL;
      ST_DER_MUL:  state_d = ST_DER_DIV;
      ST_DER_DIV:  state_d = (dt_q == '0) ? ST_KP_MUL : ST_DER_WAIT;
      ST_DER_WAIT: if (div_rsp.done) state_d = ST_KP_MUL;
      ST_KP_MUL:   state_d = ST_KI_LO;
      ST_KI_LO:    state_d = ST_KI_HI;
      ST_KI_HI:    state_d = ST_KD_LO;
      ST_KD_LO:    state_d = ST_KD_HI;
      ST_KD_HI:    state_d = ST_ACC_LAST;
      ST_ACC_LAST: state_d = ST_DONE;
      ST_DONE:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Magnitudes and signs feeding the multiplier
  logic [ERR_W:0]    diff;      // err - previous error, 33 bit signed
  logic [ERR_W-1:0]  diff_mag;
  logic [ERR_W-1:0]  err_mag;
  logic [INT_W-1:0]  integ_mag;

  always_comb begin
    diff      = {err_q[ERR_W-1], err_q} - {prev_q[ERR_W-1], prev_q};
    diff_mag  = diff[ERR_W] ? ERR_W'(-diff) : diff[ERR_W-1:0];
    err_mag   = err_q[ERR_W-1] ? -err_q : err_q;
    integ_mag = integ_q[INT_W-1] ? -integ_q : integ_q;
  end

  // Outputs of the sequencer: divider request, multiplier operands, term control
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic                      term_en, term_sh, term_add;

  always_comb begin
    in_i.ready    = (state_q == ST_IDLE);
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    mul_a         = '0;
    mul_b         = '0;
    term_en       = 1'b0;
    term_sh       = 1'b0;
    term_add      = 1'b0;
    unique case (state_q)
      ST_RES_MUL: begin
        mul_a = MUL_A_W'(series_q);
        mul_b = MUL_B_W'(ADC_FULL - adc_q);
      end
      ST_RES_DIV: begin
        div_req.start = (adc_q != '0);
        div_req.num   = mul_q[NUM_W-1:0];
        div_req.den   = DEN_W'(adc_q);
      end
      ST_ERR_DIV: begin
        div_req.start = (ohms_q != '0);
        div_req.num   = {target_q, {ERR_FRAC{1'b0}}};
        div_req.den   = DEN_W'(ohms_q);
      end
      ST_INT_MUL: begin
        mul_a = {err_q[ERR_W-1], err_q};
        mul_b = MUL_B_W'(dt_q);
      end
      ST_DER_MUL: begin
        mul_a = MS_PER_S;
        mul_b = diff_mag;
      end
      ST_DER_DIV: begin
        div_req.start = (dt_q != '0);
        div_req.num   = mul_q[NUM_W-1:0];
        div_req.den   = DEN_W'(dt_q);
      end
      // A negative operand flips the term: the sum is kept as -u
      ST_KP_MUL: begin
        mul_a    = {kp_q[31], kp_q};
        mul_b    = err_mag;
        term_en  = 1'b1;
        term_add = err_q[ERR_W-1];
      end
      ST_KI_LO: begin
        mul_a    = {ki_q[31], ki_q};
        mul_b    = integ_mag[31:0];
        term_en  = 1'b1;
        term_add = integ_q[INT_W-1];
      end
      ST_KI_HI: begin
        mul_a    = {ki_q[31], ki_q};
        mul_b    = integ_mag[63:32];
        term_en  = 1'b1;
        term_sh  = 1'b1;
        term_add = integ_q[INT_W-1];
      end
      ST_KD_LO: begin
        mul_a    = {kd_q[31], kd_q};
        mul_b    = dmag_q[31:0];
        term_en  = 1'b1;
        term_add = dneg_q;
      end
      ST_KD_HI: begin
        mul_a    = {kd_q[31], kd_q};
        mul_b    = MUL_B_W'(dmag_q[NUM_W-1:32]);
        term_en  = 1'b1;
        term_sh  = 1'b1;
        term_add = dneg_q;
      end
      default: ;
    endcase
  end

  // Shared multiplier, product registered
  logic signed [MUL_P_W-1:0] mul_p;
  assign mul_p = mul_a * $signed({1'b0, mul_b});

  // Saturating integral update
  logic [INT_W:0] int_sum;
  logic [INT_W-1:0] int_next;
  always_comb begin
    int_sum = {integ_q[INT_W-1], integ_q} + {mul_q[INT_W-1], mul_q[INT_W-1:0]};
    if (int_sum[INT_W] != int_sum[INT_W-1])
      int_next = int_sum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
    else
      int_next = int_sum[INT_W-1:0];
  end

  // Accumulator term
  logic [ACC_W-1:0] term;
  always_comb begin
    term = {{(ACC_W-MUL_P_W){mul_q[MUL_P_W-1]}}, mul_q};
    if (acc_sh_q)
      term = term << 32;
  end

  // Control state, integral and previous error
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      integ_q   <= '0;
      prev_q    <= '0;
      acc_en_q  <= 1'b0;
      acc_sh_q  <= 1'b0;
      acc_add_q <= 1'b0;
      oval_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      acc_en_q  <= term_en;
      acc_sh_q  <= term_sh;
      acc_add_q <= term_add;
      if (wr_target)
        integ_q <= '0;
      else if (state_q == ST_INT_MUL && target_q == '0)
        integ_q <= '0;
      else if (state_q == ST_INT_ADD)
        integ_q <= int_next;
      if (state_q == ST_DER_MUL)
        prev_q <= err_q;
      if (state_q == ST_DONE && out_free)
        oval_q <= 1'b1;
      else if (out_o.ready)
        oval_q <= 1'b0;
    end
  end

  // Result decode from the accumulated -u
  logic [7:0]        duty;
  clamp_e            clamp;
  logic [OHMS_W-1:0] ohms_diff;
  logic [30:0]       diff100;
  logic              settled;

  always_comb begin
    if (acc_q[ACC_W-1]) begin
      duty  = 8'd0;
      clamp = CLAMP_LOW;
    end else if (acc_q > DUTY_TOP) begin
      duty  = 8'd255;
      clamp = CLAMP_HIGH;
    end else begin
      duty  = acc_q[FRAC+7:FRAC];
      clamp = CLAMP_NONE;
    end
    ohms_diff = (ohms_q > target_q) ? ohms_q - target_q : target_q - ohms_q;
    diff100   = (31'(ohms_diff) << 6) + (31'(ohms_diff) << 5) + (31'(ohms_diff) << 2);
    settled   = (diff100 <= 31'(target_q));
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mul_q <= mul_p;
    if (in_xfer) begin
      adc_q <= in_i.adc_sample;
      dt_q  <= in_i.step_ms;
      acc_q <= '0;
    end else if (acc_en_q) begin
      acc_q <= acc_add_q ? acc_q + term : acc_q - term;
    end
    unique case (state_q)
      ST_RES_DIV:
        if (adc_q == '0) ohms_q <= OHMS_MAX;
      ST_RES_WAIT:
        if (div_rsp.done)
          ohms_q <= (|div_rsp.quot[NUM_W-1:OHMS_W]) ? OHMS_MAX
                                                    : div_rsp.quot[OHMS_W-1:0];
      ST_ERR_DIV:
        if (ohms_q == '0) err_q <= (target_q == '0) ? -ERR_ONE : ERR_MAX;
      ST_ERR_WAIT:
        if (div_rsp.done)
          err_q <= (div_rsp.quot > ERR_LIM) ? ERR_MAX
                                            : div_rsp.quot[ERR_W-1:0] - ERR_ONE;
      ST_DER_MUL:
        dneg_q <= diff[ERR_W];
      ST_DER_DIV:
        if (dt_q == '0) dmag_q <= '0;
      ST_DER_WAIT:
        if (div_rsp.done) dmag_q <= div_rsp.quot;
      default: ;
    endcase
    if (state_q == ST_DONE && out_free) begin
      duty_q     <= duty;
      oohms_q    <= ohms_q;
      osettled_q <= settled;
      oclamp_q   <= clamp;
    end
  end

  assign out_o.valid         = oval_q;
  assign out_o.heater_duty   = duty_q;
  assign out_o.measured_ohms = oohms_q;
  assign out_o.settled       = osettled_q;
  assign out_o.clamp_state   = oclamp_q;

endmodule
